/* src/rgsf_pkg.sv */
// Shared types and constants for the RGB-to-gray Sobel edge filter.
// Used by every module of the block; no dependencies.
package rgsf_pkg;

  localparam int LINE_DEPTH = 2048;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int GEOM_W     = 12;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam logic [GEOM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [GEOM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [GEOM_W-1:0] GEOM_MIN     = 12'd3;
  localparam logic [GEOM_W-1:0] WIDTH_MAX    = GEOM_W'(LINE_DEPTH);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] edge_magnitude;
    logic       line_end;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } column_t;

  typedef struct packed {
    logic emit;
    logic line_end;
    logic frame_end;
  } flags_t;

endpackage

/* src/rgsf_gray.sv */
// BT.709 luma stage: registered weighted products, summed and truncated.
// Depends on rgsf_pkg.
module rgsf_gray
  import rgsf_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  pixel_t     pix,
  output logic [7:0] gray
);

  logic [23:0] prod_r_r, prod_g_r, prod_b_r;
  logic [23:0] acc;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r_r <= 24'(W_RED * 24'(pix.red));
      prod_g_r <= 24'(W_GREEN * 24'(pix.green));
      prod_b_r <= 24'(W_BLUE * 24'(pix.blue));
    end
  end

  assign acc  = prod_r_r + prod_g_r + prod_b_r;
  assign gray = acc[23:16];

endmodule

/* src/rgsf_line_buf.sv */
// One line of gray history: single write port, registered read port.
// Depends on rgsf_pkg.
module rgsf_line_buf
  import rgsf_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data
);

  logic [7:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/rgsf_win_cell.sv */
// Window cell: holds one 3-pixel column, takes its neighbour's on shift.
// Depends on rgsf_pkg.
module rgsf_win_cell
  import rgsf_pkg::*;
(
  input  logic    clk,
  input  logic    shift_en,
  input  column_t col_in,
  output column_t col_out
);

  column_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

/* src/rgsf_sobel.sv */
// Sobel gradients over a 3-column window; registers |gx| and |gy|.
// Depends on rgsf_pkg.
module rgsf_sobel
  import rgsf_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  column_t    c0,
  input  column_t    c1,
  input  column_t    c2,
  output logic [9:0] abs_gx,
  output logic [9:0] abs_gy
);

  logic [9:0]        sx_new, sx_old, sy_bot, sy_top;
  logic signed [10:0] gx, gy;
  logic [9:0]        ax_r, ay_r;

  always_comb begin
    sx_new = 10'(c2.top) + {1'b0, c2.mid, 1'b0} + 10'(c2.bot);
    sx_old = 10'(c0.top) + {1'b0, c0.mid, 1'b0} + 10'(c0.bot);
    sy_bot = 10'(c0.bot) + {1'b0, c1.bot, 1'b0} + 10'(c2.bot);
    sy_top = 10'(c0.top) + {1'b0, c1.top, 1'b0} + 10'(c2.top);
    gx = $signed({1'b0, sx_new}) - $signed({1'b0, sx_old});
    gy = $signed({1'b0, sy_bot}) - $signed({1'b0, sy_top});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= gx[10] ? 10'(-gx) : gx[9:0];
      ay_r <= gy[10] ? 10'(-gy) : gy[9:0];
    end
  end

  assign abs_gx = ax_r;
  assign abs_gy = ay_r;

endmodule

/* src/rgb_gray_sobel_edge_filter_top.sv */
// Top level of the RGB-to-gray Sobel edge filter.
// Depends on rgsf_pkg, rgsf_gray, rgsf_line_buf, rgsf_win_cell, rgsf_sobel.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one RGB pixel item per
//   cycle in raster order; frame_start marks the first pixel of a frame.
//   Output channel out_valid/out_stall/out_data carries one edge magnitude
//   item for each interior pixel, with line_end and frame_end flags.
//   Border pixels produce no item.
//   Geometry is set through the APB port: frame_width at 0x0, frame_height
//   at 0x4; write only while the block is idle.
//   Throughput: one pixel per cycle while no result is held by out_stall, set
//   by the line buffer read port and the shift of the window cell chain,
//   both of which move once per item. After the pixel completing a window
//   is accepted, the result crosses gray, cell, gradient and output registers.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall rises in the same cycle.
//   Reset clears the pipeline valid bits, the position counters and the geometry
//   registers (640 x 480); line buffer contents are left as they are.
module rgb_gray_sobel_edge_filter_top
  import rgsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pixel_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GEOM_W-1:0] width_r, height_r;
  logic [GEOM_W-1:0] width_use, height_use;
  logic              cfg_wr;

  logic [IDX_W-1:0]  col_r, col_nxt, col_cur;
  logic [GEOM_W-1:0] row_r, row_nxt, row_cur;
  logic              adv, take;
  flags_t            flags0;

  logic              s1_v_r;
  flags_t            s1_flags_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              fwd_r;
  logic [7:0]        fwd_one_r, fwd_two_r;
  logic [7:0]        rd_one, rd_two, gray, m2, t2;

  logic              s2_v_r;
  flags_t            s2_flags_r;
  column_t           col_new, win0, win1, win2;
  logic              shift_en;

  logic              s3_v_r;
  flags_t            s3_flags_r;
  logic [9:0]        abs_gx, abs_gy;
  logic [10:0]       mag_sum;

  logic              out_valid_r;
  result_t           out_data_r;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  width_r  <= pwdata[GEOM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[GEOM_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(32-GEOM_W){1'b0}}, width_r};
      REG_FRAME_HEIGHT: prdata = {{(32-GEOM_W){1'b0}}, height_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r < GEOM_MIN) begin
      width_use = GEOM_MIN;
    end else if (width_r > WIDTH_MAX) begin
      width_use = WIDTH_MAX;
    end else begin
      width_use = width_r;
    end
    height_use = (height_r < GEOM_MIN) ? GEOM_MIN : height_r;
  end

  // handshake: everything moves together unless a result is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign take     = in_valid && adv;

  // position
  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    flags0.line_end  = GEOM_W'(col_cur) >= (width_use - 1'b1);
    flags0.frame_end = flags0.line_end && (row_cur >= (height_use - 1'b1));
    flags0.emit      = (row_cur >= GEOM_W'(2)) && (col_cur >= IDX_W'(2));
    if (flags0.line_end) begin
      col_nxt = '0;
      row_nxt = flags0.frame_end ? '0 : row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: gray, line buffer read, forward the write still in flight
  rgsf_gray u_gray (
    .clk  (clk),
    .en   (adv),
    .pix  (in_data),
    .gray (gray)
  );

  rgsf_line_buf u_line_one (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (col_cur),
    .rd_data (rd_one),
    .wr_en   (adv && s1_v_r),
    .wr_addr (s1_idx_r),
    .wr_data (gray)
  );

  rgsf_line_buf u_line_two (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (col_cur),
    .rd_data (rd_two),
    .wr_en   (adv && s1_v_r),
    .wr_addr (s1_idx_r),
    .wr_data (m2)
  );

  assign m2 = fwd_r ? fwd_one_r : rd_one;
  assign t2 = fwd_r ? fwd_two_r : rd_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      fwd_r  <= in_valid && s1_v_r && (col_cur == s1_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags_r <= flags0;
      s1_idx_r   <= col_cur;
      fwd_one_r  <= gray;
      fwd_two_r  <= m2;
    end
  end

  // stage 2: window cell chain
  assign shift_en    = adv && s1_v_r;
  assign col_new.top = t2;
  assign col_new.mid = m2;
  assign col_new.bot = gray;

  rgsf_win_cell u_cell2 (.clk(clk), .shift_en(shift_en), .col_in(col_new), .col_out(win2));
  rgsf_win_cell u_cell1 (.clk(clk), .shift_en(shift_en), .col_in(win2), .col_out(win1));
  rgsf_win_cell u_cell0 (.clk(clk), .shift_en(shift_en), .col_in(win1), .col_out(win0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flags_r <= s1_flags_r;
    end
  end

  // stage 3: gradients
  rgsf_sobel u_sobel (
    .clk    (clk),
    .en     (adv),
    .c0     (win0),
    .c1     (win1),
    .c2     (win2),
    .abs_gx (abs_gx),
    .abs_gy (abs_gy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r && s2_flags_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_flags_r <= s2_flags_r;
    end
  end

  // output register
  assign mag_sum = 11'(abs_gx) + 11'(abs_gy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.edge_magnitude <= (mag_sum > 11'd255) ? 8'd255 : mag_sum[7:0];
      out_data_r.line_end       <= s3_flags_r.line_end;
      out_data_r.frame_end      <= s3_flags_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/rgb_gray_sobel_edge_filter_top_tb.sv */
// Self-checking testbench for rgb_gray_sobel_edge_filter_top: RGB pixel items in,
// edge magnitude items out, checked against an in-bench line-buffer Sobel predictor.
// Depends on rgsf_pkg and the filter RTL only.
`timescale 1ns / 100ps

module rgb_gray_sobel_edge_filter_top_tb;
  import rgsf_pkg::*;

  localparam int          MAX_LINE       = 2048;
  localparam int          MIN_SIDE       = 3;
  localparam int unsigned RED_WEIGHT     = 13933;
  localparam int unsigned GREEN_WEIGHT   = 46871;
  localparam int unsigned BLUE_WEIGHT    = 4732;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_PIXELS  = 850;
  localparam int          IDLE_PERCENT   = 29;
  localparam int          MAX_REPORTS    = 10;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pixel_t      in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_gray_sobel_edge_filter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  logic [7:0]  gray_line_one [MAX_LINE];
  logic [7:0]  gray_line_two [MAX_LINE];
  column_t     win_old;
  column_t     win_mid;
  logic [10:0] col_pos;
  logic [11:0] row_pos;
  logic [11:0] geo_width;
  logic [11:0] geo_height;

  result_t     expected_edges [$];
  result_t     edge_want;
  int          mismatches    = 0;
  int          idle_cycles   = 0;
  int unsigned pixels_sent   = 0;
  bit          in_gaps_on    = 1'b1;
  bit          out_stalls_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < MAX_LINE; i++) begin
      gray_line_one[i] = '0;
      gray_line_two[i] = '0;
    end
    win_old    = '0;
    win_mid    = '0;
    col_pos    = '0;
    row_pos    = '0;
    geo_width  = 12'd640;
    geo_height = 12'd480;
  endfunction

  function automatic void predict_edge(input pixel_t px);
    int unsigned w, h, gray;
    int          tl, ml, bl, tc, mc, bc, tr, mr, br;
    int          gx, gy, mag;
    logic        line_done, frame_done;
    result_t     res;
    w = (geo_width < MIN_SIDE) ? MIN_SIDE : (geo_width > MAX_LINE) ? MAX_LINE : geo_width;
    h = (geo_height < MIN_SIDE) ? MIN_SIDE : geo_height;
    if (px.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    gray = (RED_WEIGHT * px.red + GREEN_WEIGHT * px.green + BLUE_WEIGHT * px.blue) >> 16;
    tl = win_old.top;
    ml = win_old.mid;
    bl = win_old.bot;
    tc = win_mid.top;
    mc = win_mid.mid;
    bc = win_mid.bot;
    tr = gray_line_two[col_pos];
    mr = gray_line_one[col_pos];
    br = gray & 8'hFF;
    gray_line_two[col_pos] = gray_line_one[col_pos];
    gray_line_one[col_pos] = br[7:0];
    win_old = win_mid;
    win_mid = '{top: tr[7:0], mid: mr[7:0], bot: br[7:0]};
    line_done  = col_pos >= w - 1;
    frame_done = line_done && (row_pos >= h - 1);
    if (row_pos >= 2 && col_pos >= 2) begin
      gx  = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
      gy  = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > 255) begin
        mag = 255;
      end
      res.edge_magnitude = mag[7:0];
      res.line_end       = line_done;
      res.frame_end      = frame_done;
      expected_edges.push_back(res);
    end
    if (line_done) begin
      col_pos = '0;
      row_pos = frame_done ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 11'd1;
    end
  endfunction

  function automatic pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic start);
    pixel_t p;
    p = '{red: r, green: g, blue: b, frame_start: start};
    return p;
  endfunction

  // mix noisy, saturated and flat regions so that magnitudes span the whole range
  function automatic pixel_t random_pixel(input pixel_t prev);
    pixel_t      p;
    int unsigned mode;
    p    = prev;
    mode = $urandom_range(9);
    if (mode < 4) begin
      p.red   = 8'($urandom_range(255));
      p.green = 8'($urandom_range(255));
      p.blue  = 8'($urandom_range(255));
    end else if (mode < 6) begin
      p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    p.frame_start = 1'b0;
    return p;
  endfunction

  always @(negedge clk) begin
    out_stall <= out_stalls_on && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_edges.size() == 0) begin
        note_mismatch($sformatf("unexpected item mag %0d line_end %0b frame_end %0b",
                                out_data.edge_magnitude, out_data.line_end,
                                out_data.frame_end));
      end else begin
        edge_want = expected_edges.pop_front();
        if (out_data.edge_magnitude !== edge_want.edge_magnitude ||
            out_data.line_end !== edge_want.line_end ||
            out_data.frame_end !== edge_want.frame_end) begin
          note_mismatch($sformatf("exp mag %0d le %0b fe %0b, got mag %0d le %0b fe %0b",
                                  edge_want.edge_magnitude, edge_want.line_end,
                                  edge_want.frame_end, out_data.edge_magnitude,
                                  out_data.line_end, out_data.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t px);
    while (in_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_edge(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned npix, input bit start, input bit noisy);
    pixel_t px;
    px = '0;
    for (int unsigned i = 0; i < npix; i++) begin
      px = random_pixel(px);
      px.frame_start = (i == 0 && start) || (noisy && i != 0 && $urandom_range(199) == 0);
      send_pixel(px);
    end
  endtask

  // hold the sender until every expected item is back and the pipeline is empty
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_edges.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_geometry_reg(input logic idx);
    logic [31:0] rd;
    logic [11:0] held;
    apb_transfer(1'b0, {idx, 2'b00}, '0, rd);
    held = (idx == REG_FRAME_WIDTH) ? geo_width : geo_height;
    if (rd !== {20'd0, held}) begin
      note_mismatch($sformatf("register %0d exp %0d got %0d", idx, held, rd));
    end
  endtask

  task automatic write_geometry(input logic idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, {idx, 2'b00}, value, unused);
    if (idx == REG_FRAME_WIDTH) begin
      geo_width = value[11:0];
    end else begin
      geo_height = value[11:0];
    end
    check_geometry_reg(idx);
  endtask

  task automatic test_register_reset();
    check_geometry_reg(REG_FRAME_WIDTH);
    check_geometry_reg(REG_FRAME_HEIGHT);
  endtask

  task automatic test_default_geometry();
    send_frame(64, 1'b1, 1'b0);
  endtask

  task automatic test_pixel_extremes();
    logic [7:0] v;
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd3);
    write_geometry(REG_FRAME_HEIGHT, 32'd3);
    for (int i = 0; i < 9; i++) begin
      send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, i == 0));
    end
    for (int i = 0; i < 9; i++) begin
      v = (i % 3 == 2) ? 8'hFF : 8'h00;
      send_pixel(mk_pixel(v, v, v, 1'b0));
    end
    for (int i = 0; i < 9; i++) begin
      case (i / 3)
        0:       send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
        1:       send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
        default: send_pixel(mk_pixel(8'h00, 8'h00, 8'hFF, 1'b0));
      endcase
    end
  endtask

  task automatic test_geometry_clamps();
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd0);
    write_geometry(REG_FRAME_HEIGHT, 32'd0);
    send_frame(9, 1'b1, 1'b0);
    send_frame(9, 1'b0, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd1);
    write_geometry(REG_FRAME_HEIGHT, 32'd2);
    send_frame(9, 1'b1, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd2);
    write_geometry(REG_FRAME_HEIGHT, 32'd1);
    send_frame(9, 1'b1, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'hFFFF_F003);
    write_geometry(REG_FRAME_HEIGHT, 32'h8000_0003);
    send_frame(9, 1'b1, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd4095);
    send_frame(20, 1'b1, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd2048);
    send_frame(20, 1'b1, 1'b0);
  endtask

  task automatic test_tall_frame();
    wait_for_idle();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    write_geometry(REG_FRAME_WIDTH, 32'd3);
    write_geometry(REG_FRAME_HEIGHT, 32'd4095);
    send_frame(3 * 100, 1'b1, 1'b0);
    wait_for_idle();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  task automatic test_frame_restart();
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd6);
    write_geometry(REG_FRAME_HEIGHT, 32'd5);
    send_frame(14, 1'b1, 1'b0);
    send_frame(30, 1'b1, 1'b0);
    send_frame(30, 1'b0, 1'b0);
  endtask

  task automatic test_midframe_geometry();
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd10);
    write_geometry(REG_FRAME_HEIGHT, 32'd8);
    send_frame(5 * 10 + 7, 1'b1, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_WIDTH, 32'd5);
    send_frame(8, 1'b0, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_HEIGHT, 32'd4);
    send_frame(3, 1'b0, 1'b0);
    send_frame(20, 1'b0, 1'b0);
    send_frame(7, 1'b0, 1'b0);
    wait_for_idle();
    write_geometry(REG_FRAME_HEIGHT, 32'd6);
    send_frame(23, 1'b0, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned first, w, h, frames, npix, pick, phase;
    first = pixels_sent;
    phase = 0;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      wait_for_idle();
      w = ($urandom_range(4) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      write_geometry(REG_FRAME_WIDTH, w);
      write_geometry(REG_FRAME_HEIGHT, h);
      in_gaps_on    = (phase != 4);
      out_stalls_on = (phase != 4);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        pick = $urandom_range(99);
        npix = (pick < 10) ? $urandom_range(1, w * h - 1) : w * h;
        send_frame(npix, (f == 0) || (pick >= 20), 1'b1);
      end
      phase++;
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_register_reset();
    test_default_geometry();
    test_pixel_extremes();
    test_geometry_clamps();
    test_tall_frame();
    test_frame_restart();
    test_midframe_geometry();
    test_random_frames();
    wait_for_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
